[hw/rtl/slep_pkg.sv]
// Shared types and constants for the start/command/length/end frame parser.
// Holds the controller/datapath command and status structs and the event codes.
// No dependencies.
package slep_pkg;

  // Default largest payload a frame may carry
  localparam int unsigned PAY_LIMIT_DEF = 32;

  // Configuration bus geometry
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Output stream geometry
  localparam int unsigned OUT_TDATA_W = 128;
  localparam int unsigned OUT_TUSER_W = 3;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_START_BYTE = 2'd0,
    REG_END_BYTE   = 2'd1,
    REG_WRITE_CMD  = 2'd2,
    REG_READ_CMD   = 2'd3
  } reg_idx_e;

  // Per-request event codes
  typedef enum logic [2:0] {
    EV_OK   = 3'd0,
    EV_DROP = 3'd1,
    EV_CMD  = 3'd2,
    EV_LEN  = 3'd3,
    EV_EOF  = 3'd4,
    EV_GOOD = 3'd5
  } ev_e;

  // Controller states: five parse phases plus payload readout
  typedef enum logic [2:0] {
    PH_SOF = 3'd0,
    PH_CMD = 3'd1,
    PH_LEN = 3'd2,
    PH_PAY = 3'd3,
    PH_EOF = 3'd4,
    PH_RD  = 3'd5,
    PH_LD  = 3'd6
  } phase_e;

  // Configuration registers
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] write_command;
    logic [7:0] read_command;
  } cfg_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_start;
    logic is_cmd;
    logic len_big;
    logic len_zero;
    logic fill_done;
    logic is_end;
    logic held_empty;
    logic rd_last;
    logic out_free;
  } status_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_one;
    ev_e  ev;
    logic load_empty;
    logic load_pay;
    logic hold_cmd;
    logic take_len;
    logic clr_frame;
    logic fill_clr;
    logic store_pay;
    logic inc_drop;
    logic inc_ok;
    logic inc_err;
    logic rd_start;
    logic rd_en;
    logic rd_adv;
  } cmd_t;

endpackage

[hw/rtl/slep_regs.sv]
// Configuration register file behind an APB-style port.
// Depends on slep_pkg for the register map and the cfg_t struct.
module slep_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [slep_pkg::APB_AW-1:0]         paddr,
  input  logic [slep_pkg::APB_DW-1:0]         pwdata,
  output logic [slep_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  output slep_pkg::cfg_t                      cfg_o
);
  import slep_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_START_BYTE: cfg_d.start_byte    = pwdata[7:0];
        REG_END_BYTE:   cfg_d.end_byte      = pwdata[7:0];
        REG_WRITE_CMD:  cfg_d.write_command = pwdata[7:0];
        REG_READ_CMD:   cfg_d.read_command  = pwdata[7:0];
        default:        cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= 8'hA5;
      cfg_q.end_byte      <= 8'h5A;
      cfg_q.write_command <= 8'h01;
      cfg_q.read_command  <= 8'h02;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_START_BYTE: prdata = APB_DW'(cfg_q.start_byte);
      REG_END_BYTE:   prdata = APB_DW'(cfg_q.end_byte);
      REG_WRITE_CMD:  prdata = APB_DW'(cfg_q.write_command);
      REG_READ_CMD:   prdata = APB_DW'(cfg_q.read_command);
      default:        prdata = '0;
    endcase
  end

endmodule

[hw/rtl/slep_ctrl.sv]
// Parser controller: frame phase state machine and payload readout sequencer.
// Depends on slep_pkg for phase_e, status_t and cmd_t.
module slep_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  slep_pkg::status_t status_i,
  output slep_pkg::cmd_t    cmd_o
);
  import slep_pkg::*;

  phase_e state_q, state_d;
  logic   parsing;
  logic   acc;

  // Requests are taken only in the parse phases, with room in the output register
  assign parsing    = (state_q != PH_RD) && (state_q != PH_LD);
  assign s_tready_o = parsing && status_i.out_free;
  assign acc        = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_SOF;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      PH_SOF: begin
        if (acc && status_i.is_start) state_d = PH_CMD;
      end
      PH_CMD: begin
        if (acc) begin
          if (status_i.is_cmd)        state_d = PH_LEN;
          else if (status_i.is_start) state_d = PH_CMD;
          else                        state_d = PH_SOF;
        end
      end
      PH_LEN: begin
        if (acc) begin
          if (status_i.len_big)       state_d = status_i.is_start ? PH_CMD : PH_SOF;
          else if (status_i.len_zero) state_d = PH_EOF;
          else                        state_d = PH_PAY;
        end
      end
      PH_PAY: begin
        if (acc && status_i.fill_done) state_d = PH_EOF;
      end
      PH_EOF: begin
        if (acc) begin
          if (!status_i.is_end)         state_d = status_i.is_start ? PH_CMD : PH_SOF;
          else if (status_i.held_empty) state_d = PH_SOF;
          else                          state_d = PH_RD;
        end
      end
      PH_RD: begin
        state_d = PH_LD;
      end
      PH_LD: begin
        if (status_i.out_free) state_d = status_i.rd_last ? PH_SOF : PH_RD;
      end
      default: state_d = PH_SOF;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o    = '0;
    cmd_o.ev = EV_OK;
    unique case (state_q)
      PH_SOF: begin
        if (acc) begin
          cmd_o.load_one = 1'b1;
          if (!status_i.is_start) begin
            cmd_o.ev       = EV_DROP;
            cmd_o.inc_drop = 1'b1;
          end
        end
      end
      PH_CMD: begin
        if (acc) begin
          cmd_o.load_one = 1'b1;
          if (status_i.is_cmd) begin
            cmd_o.hold_cmd = 1'b1;
          end else begin
            cmd_o.ev        = EV_CMD;
            cmd_o.inc_err   = 1'b1;
            cmd_o.clr_frame = 1'b1;
          end
        end
      end
      PH_LEN: begin
        if (acc) begin
          cmd_o.load_one = 1'b1;
          cmd_o.take_len = 1'b1;
          if (status_i.len_big) begin
            cmd_o.ev        = EV_LEN;
            cmd_o.inc_err   = 1'b1;
            cmd_o.clr_frame = 1'b1;
          end else begin
            cmd_o.fill_clr = 1'b1;
          end
        end
      end
      PH_PAY: begin
        if (acc) begin
          cmd_o.load_one  = 1'b1;
          cmd_o.store_pay = 1'b1;
        end
      end
      PH_EOF: begin
        if (acc) begin
          if (!status_i.is_end) begin
            cmd_o.load_one  = 1'b1;
            cmd_o.ev        = EV_EOF;
            cmd_o.inc_err   = 1'b1;
            cmd_o.clr_frame = 1'b1;
          end else if (status_i.held_empty) begin
            cmd_o.inc_ok     = 1'b1;
            cmd_o.load_empty = 1'b1;
            cmd_o.clr_frame  = 1'b1;
          end else begin
            cmd_o.inc_ok   = 1'b1;
            cmd_o.rd_start = 1'b1;
          end
        end
      end
      PH_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      PH_LD: begin
        if (status_i.out_free) begin
          cmd_o.load_pay = 1'b1;
          if (status_i.rd_last) cmd_o.clr_frame = 1'b1;
          else                  cmd_o.rd_adv    = 1'b1;
        end
      end
      default: cmd_o.clr_frame = 1'b1;
    endcase
  end

endmodule

[hw/rtl/slep_dp.sv]
// Parser datapath: frame fields, payload memory, event counters, output register.
// Depends on slep_pkg; driven by slep_ctrl through cmd_t and reports status_t.
module slep_dp #(
  parameter int unsigned PAY_LIMIT = slep_pkg::PAY_LIMIT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  slep_pkg::cfg_t                       cfg_i,
  input  logic [7:0]                           rx_byte_i,
  input  slep_pkg::cmd_t                       cmd_i,
  output slep_pkg::status_t                    status_o,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [slep_pkg::OUT_TDATA_W-1:0]     m_tdata_o,
  output logic [slep_pkg::OUT_TUSER_W-1:0]     m_tuser_o,
  output logic                                 m_tlast_o
);
  import slep_pkg::*;

  localparam int unsigned AW = (PAY_LIMIT > 1) ? $clog2(PAY_LIMIT) : 1;
  localparam int unsigned FW = $clog2(PAY_LIMIT + 1);

  // Frame fields
  logic [7:0]    held_cmd_q;
  logic [7:0]    held_len_q;
  logic [FW-1:0] fill_q;
  logic [AW-1:0] rd_idx_q;
  logic [7:0]    rd_data_q;
  logic [7:0]    rd_idx8;

  // Payload memory
  logic [7:0] mem [PAY_LIMIT];

  // Counters
  logic [15:0] drop_q, ok_q, err_q, cerr_q, lerr_q, eerr_q;
  logic [15:0] drop_d, ok_d, err_d, cerr_d, lerr_d, eerr_d;

  // Output register
  logic        out_valid_q;
  ev_e         out_ev_q;
  logic [7:0]  out_cmd_q;
  logic [5:0]  out_len_q;
  logic [7:0]  out_pb_q;
  logic [4:0]  out_pi_q;
  logic        out_last_q;
  logic [15:0] out_drop_q, out_ok_q, out_err_q, out_cerr_q, out_lerr_q, out_eerr_q;
  logic        load;

  assign rd_idx8 = 8'(rd_idx_q);

  // Status toward the controller
  always_comb begin
    status_o.is_start   = (rx_byte_i == cfg_i.start_byte);
    status_o.is_cmd     = (rx_byte_i == cfg_i.write_command) ||
                          (rx_byte_i == cfg_i.read_command);
    status_o.len_big    = (rx_byte_i > 8'(PAY_LIMIT));
    status_o.len_zero   = (rx_byte_i == 8'd0);
    status_o.fill_done  = ((8'(fill_q) + 8'd1) >= held_len_q);
    status_o.is_end     = (rx_byte_i == cfg_i.end_byte);
    status_o.held_empty = (held_len_q == 8'd0);
    status_o.rd_last    = ((rd_idx8 + 8'd1) == held_len_q);
    status_o.out_free   = !out_valid_q || m_tready_i;
  end

  // Frame field registers; a frame clear wins over a capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cmd_q <= '0;
      held_len_q <= '0;
      fill_q     <= '0;
      rd_idx_q   <= '0;
    end else begin
      if (cmd_i.clr_frame) begin
        held_cmd_q <= '0;
        held_len_q <= '0;
        fill_q     <= '0;
      end else begin
        if (cmd_i.hold_cmd) held_cmd_q <= rx_byte_i;
        if (cmd_i.take_len) held_len_q <= rx_byte_i;
        if (cmd_i.fill_clr)       fill_q <= '0;
        else if (cmd_i.store_pay) fill_q <= fill_q + FW'(1);
      end
      if (cmd_i.rd_start)    rd_idx_q <= '0;
      else if (cmd_i.rd_adv) rd_idx_q <= rd_idx_q + AW'(1);
    end
  end

  // Payload memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_pay) mem[fill_q[AW-1:0]] <= rx_byte_i;
    if (cmd_i.rd_en)     rd_data_q <= mem[rd_idx_q];
  end

  // Counter updates, all wrap at 16 bits
  always_comb begin
    drop_d = drop_q;
    ok_d   = ok_q;
    err_d  = err_q;
    cerr_d = cerr_q;
    lerr_d = lerr_q;
    eerr_d = eerr_q;
    if (cmd_i.inc_drop) drop_d = drop_q + 16'd1;
    if (cmd_i.inc_ok)   ok_d   = ok_q + 16'd1;
    if (cmd_i.inc_err) begin
      err_d = err_q + 16'd1;
      if (cmd_i.ev == EV_CMD) cerr_d = cerr_q + 16'd1;
      if (cmd_i.ev == EV_LEN) lerr_d = lerr_q + 16'd1;
      if (cmd_i.ev == EV_EOF) eerr_d = eerr_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= '0;
      ok_q   <= '0;
      err_q  <= '0;
      cerr_q <= '0;
      lerr_q <= '0;
      eerr_q <= '0;
    end else begin
      drop_q <= drop_d;
      ok_q   <= ok_d;
      err_q  <= err_d;
      cerr_q <= cerr_d;
      lerr_q <= lerr_d;
      eerr_q <= eerr_d;
    end
  end

  assign load = cmd_i.load_one || cmd_i.load_empty || cmd_i.load_pay;

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload; counters are taken after this request's update
  always_ff @(posedge clk_i) begin
    if (load) begin
      priority if (cmd_i.load_pay) begin
        out_ev_q   <= EV_GOOD;
        out_cmd_q  <= held_cmd_q;
        out_len_q  <= held_len_q[5:0];
        out_pb_q   <= rd_data_q;
        out_pi_q   <= rd_idx8[4:0];
        out_last_q <= status_o.rd_last;
      end else if (cmd_i.load_empty) begin
        out_ev_q   <= EV_GOOD;
        out_cmd_q  <= held_cmd_q;
        out_len_q  <= '0;
        out_pb_q   <= '0;
        out_pi_q   <= '0;
        out_last_q <= 1'b1;
      end else begin
        out_ev_q   <= cmd_i.ev;
        out_cmd_q  <= '0;
        out_len_q  <= '0;
        out_pb_q   <= '0;
        out_pi_q   <= '0;
        out_last_q <= 1'b1;
      end
      out_drop_q <= drop_d;
      out_ok_q   <= ok_d;
      out_err_q  <= err_d;
      out_cerr_q <= cerr_d;
      out_lerr_q <= lerr_d;
      out_eerr_q <= eerr_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_ev_q;
  assign m_tdata_o  = {5'd0, out_eerr_q, out_lerr_q, out_cerr_q, out_err_q, out_ok_q,
                       out_drop_q, out_pi_q, out_pb_q, out_len_q, out_cmd_q};

endmodule

[hw/rtl/sof_len_eof_frame_parser_unit.sv]
// Top level of the start/command/length/payload/end frame parser.
// Depends on slep_pkg, slep_regs, slep_ctrl and slep_dp.

// The parser takes one received byte per request on the slave stream and
// returns a status result for it on the master stream: the event code in
// tuser and the frame fields plus the six running 16-bit counters in tdata.
// A byte that does not end a good frame gives one result in the cycle after
// it is taken, so ordinary bytes flow at one per cycle while the consumer
// keeps up. The end byte of a good frame with n payload bytes replays the
// payload from the internal payload memory, one result per byte, tlast on
// the final one; each byte is read from the registered port in PH_RD, loaded
// in PH_LD, and no byte is taken until the readout ends. An empty frame gives
// one result. The four marker and command bytes sit in APB registers at byte
// addresses 0, 4, 8 and 12; the user must write them only while idle (not enforced).
module sof_len_eof_frame_parser_unit #(
  parameter int unsigned PAY_LIMIT = slep_pkg::PAY_LIMIT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [slep_pkg::APB_AW-1:0]          paddr,
  input  logic [slep_pkg::APB_DW-1:0]          pwdata,
  output logic [slep_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready,
  // Received bytes
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // rx_byte[7:0]
  // Results
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // frame_cmd[7:0], frame_len[13:8], payload_byte[21:14], payload_index[26:22],
  // dropped_bytes[42:27], good_frames[58:43], bad_frames[74:59],
  // bad_cmd_frames[90:75], bad_len_frames[106:91], bad_eof_frames[122:107], zero pad
  output logic [slep_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic [slep_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,  // event_res[2:0]
  output logic                                 m_axis_tlast   // last
);
  import slep_pkg::*;

  cfg_t    cfg;
  status_t status;
  cmd_t    cmd;

  // Configuration registers
  slep_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Phase controller
  slep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  slep_dp #(
    .PAY_LIMIT (PAY_LIMIT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .rx_byte_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the start/command/length/payload/end frame parser.
// Streams received bytes in, predicts every status result in step and checks the result stream.
// Depends on slep_pkg and sof_len_eof_frame_parser_unit.
module testbench;
  import slep_pkg::*;

  localparam int unsigned MAX_PAY     = PAY_LIMIT_DEF;
  localparam int unsigned STALL_LIMIT = 3000;  // cycles with no transfer on either stream
  localparam int unsigned HOLD_CYCLES = 250;   // long output hold-off

  // Expected status of one result request
  typedef struct {
    ev_e        ev;
    logic [7:0] cmd;
    logic [5:0] len;
    logic [7:0] pb;
    logic [4:0] pi;
    logic       last;
    logic [15:0] drops, goods, bads, bad_cmds, bad_lens, bad_eofs;
  } rx_status_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel, penable, pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                s_axis_tvalid, s_axis_tready;
  logic [7:0]          s_axis_tdata;   // rx_byte[7:0]
  logic                m_axis_tvalid, m_axis_tready;
  // frame_cmd, frame_len, payload_byte, payload_index, six counters, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;  // event_res[2:0]
  logic                   m_axis_tlast;

  // Predictor state
  cfg_t        marker_cfg;
  phase_e      cur_phase;
  logic [7:0]  frame_cmd_r, frame_len_r;
  int unsigned fill_pos;
  logic [7:0]  payload_mem [MAX_PAY];
  logic [15:0] cnt_drop, cnt_good, cnt_bad, cnt_bad_cmd, cnt_bad_len, cnt_bad_eof;

  rx_status_t  status_q [$];
  int unsigned mismatch_count;
  int unsigned rx_sent, results_seen;
  bit          idle_tx;     // random gaps on the input stream
  bit          ready_free;  // output ready held high
  bit          hold_req;    // ask the consumer for a long hold-off

  sof_len_eof_frame_parser_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_status(ev_e ev, logic [7:0] cmd, logic [5:0] len,
                                      logic [7:0] pb, logic [4:0] pi, logic last);
    rx_status_t s;
    s.ev = ev; s.cmd = cmd; s.len = len; s.pb = pb; s.pi = pi; s.last = last;
    s.drops = cnt_drop; s.goods = cnt_good; s.bads = cnt_bad;
    s.bad_cmds = cnt_bad_cmd; s.bad_lens = cnt_bad_len; s.bad_eofs = cnt_bad_eof;
    status_q.push_back(s);
  endfunction

  function automatic void clear_frame_state();
    cur_phase   = PH_SOF;
    frame_cmd_r = 8'h00;
    frame_len_r = 8'h00;
    fill_pos    = 0;
  endfunction

  // Drop the frame; a start byte as the offending byte opens a new frame
  function automatic void frame_fault(ev_e ev, logic [7:0] b);
    cnt_bad++;
    if (ev == EV_CMD) cnt_bad_cmd++;
    if (ev == EV_LEN) cnt_bad_len++;
    if (ev == EV_EOF) cnt_bad_eof++;
    clear_frame_state();
    if (b == marker_cfg.start_byte) cur_phase = PH_CMD;
  endfunction

  function automatic void parse_rx_byte(logic [7:0] b);
    ev_e         ev;
    int unsigned n;
    logic [7:0]  cmd;
    ev = EV_OK;
    case (cur_phase)
      PH_SOF: begin
        if (b == marker_cfg.start_byte) cur_phase = PH_CMD;
        else begin
          cnt_drop++;
          ev = EV_DROP;
        end
      end
      PH_CMD: begin
        if (b == marker_cfg.write_command || b == marker_cfg.read_command) begin
          frame_cmd_r = b;
          cur_phase   = PH_LEN;
        end else begin
          ev = EV_CMD;
          frame_fault(ev, b);
        end
      end
      PH_LEN: begin
        frame_len_r = b;
        if (b > MAX_PAY) begin
          ev = EV_LEN;
          frame_fault(ev, b);
        end else begin
          fill_pos  = 0;
          cur_phase = (b == 8'h00) ? PH_EOF : PH_PAY;
        end
      end
      PH_PAY: begin
        if (fill_pos < MAX_PAY) payload_mem[fill_pos] = b;
        fill_pos++;
        if (fill_pos >= frame_len_r) cur_phase = PH_EOF;
      end
      PH_EOF: begin
        if (b != marker_cfg.end_byte) begin
          ev = EV_EOF;
          frame_fault(ev, b);
        end else begin
          // good frame: replay the payload, one result per byte
          n   = frame_len_r;
          cmd = frame_cmd_r;
          cnt_good++;
          clear_frame_state();
          if (n == 0) push_status(EV_GOOD, cmd, 6'd0, 8'h00, 5'd0, 1'b1);
          for (int k = 0; k < n; k++)
            push_status(EV_GOOD, cmd, 6'(n), payload_mem[k], 5'(k), k + 1 == n);
          return;
        end
      end
      default: clear_frame_state();
    endcase
    push_status(ev, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h (result %0d)",
                                name, got, want, results_seen));
  endtask

  initial begin : result_checker
    rx_status_t w;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (status_q.size() == 0) report_mismatch("result with no request pending");
        else begin
          w = status_q.pop_front();
          check_field("event",          16'(m_axis_tuser),           16'(w.ev));
          check_field("frame_cmd",      16'(m_axis_tdata[7:0]),      16'(w.cmd));
          check_field("frame_len",      16'(m_axis_tdata[13:8]),     16'(w.len));
          check_field("payload_byte",   16'(m_axis_tdata[21:14]),    16'(w.pb));
          check_field("payload_index",  16'(m_axis_tdata[26:22]),    16'(w.pi));
          check_field("last",           16'(m_axis_tlast),           16'(w.last));
          check_field("dropped_bytes",  m_axis_tdata[42:27],         w.drops);
          check_field("good_frames",    m_axis_tdata[58:43],         w.goods);
          check_field("bad_frames",     m_axis_tdata[74:59],         w.bads);
          check_field("bad_cmd_frames", m_axis_tdata[90:75],         w.bad_cmds);
          check_field("bad_len_frames", m_axis_tdata[106:91],        w.bad_lens);
          check_field("bad_eof_frames", m_axis_tdata[122:107],       w.bad_eofs);
          check_field("tdata pad",      16'(m_axis_tdata[127:123]),  16'h0000);
        end
      end
    end
  end

  // Output ready: mostly high, short and a few long stalls, optional long hold-off
  initial begin : result_consumer
    int unsigned n;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (ready_free || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // No transfer on either stream for too long ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results pending",
                 quiet, status_q.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Send one received byte, with an optional gap in front of it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap, r;
    gap = 0;
    if (idle_tx) begin
      r = $urandom_range(0, 15);
      if (r >= 14) gap = $urandom_range(8, 30);
      else if (r >= 9) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    parse_rx_byte(b);
    rx_sent++;
  endtask

  // Stop sending and wait until every predicted result has arrived
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB read of one marker register, low byte compared
  task automatic check_marker(input reg_idx_e idx, input logic [7:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[7:0] !== want)
      report_mismatch($sformatf("register %s read %0h want %0h", idx.name(), prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // APB write of one marker register, then read it back
  task automatic write_marker(input reg_idx_e idx, input logic [7:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_START_BYTE: marker_cfg.start_byte    = v;
      REG_END_BYTE:   marker_cfg.end_byte      = v;
      REG_WRITE_CMD:  marker_cfg.write_command = v;
      REG_READ_CMD:   marker_cfg.read_command  = v;
      default: ;
    endcase
    check_marker(idx, v);
  endtask

  task automatic set_markers(input logic [7:0] sb, input logic [7:0] eb,
                             input logic [7:0] wc, input logic [7:0] rc);
    write_marker(REG_START_BYTE, sb);
    write_marker(REG_END_BYTE,   eb);
    write_marker(REG_WRITE_CMD,  wc);
    write_marker(REG_READ_CMD,   rc);
  endtask

  // One frame: mostly well formed, else a broken frame or line noise
  task automatic send_random_frame();
    int unsigned kind, len, r, n;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind >= 96) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom()));
      return;
    end
    r = $urandom_range(0, 19);
    if (r == 0) len = MAX_PAY;
    else if (r == 1) len = MAX_PAY - 1;
    else if (r < 4) len = $urandom_range(9, MAX_PAY - 2);
    else len = $urandom_range(0, 8);
    send_byte(marker_cfg.start_byte);
    // unknown command, sometimes the start byte itself
    if (kind >= 70 && kind < 78) begin
      if ($urandom_range(0, 3) == 0) b = marker_cfg.start_byte;
      else begin
        b = 8'($urandom());
        while (b == marker_cfg.write_command || b == marker_cfg.read_command)
          b = 8'($urandom());
      end
      send_byte(b);
      return;
    end
    send_byte($urandom_range(0, 1) ? marker_cfg.write_command : marker_cfg.read_command);
    // oversize length, sometimes the start byte itself
    if (kind >= 78 && kind < 85) begin
      if ($urandom_range(0, 3) == 0) send_byte(marker_cfg.start_byte);
      else send_byte(8'($urandom_range(MAX_PAY + 1, 255)));
      return;
    end
    send_byte(8'(len));
    // truncated frame: the next frame's bytes land inside this one
    n = (kind >= 92 && len > 0) ? $urandom_range(0, len - 1) : len;
    repeat (n) send_byte(8'($urandom()));
    if (n != len) return;
    if (kind >= 85 && kind < 92) begin
      if ($urandom_range(0, 3) == 0) b = marker_cfg.start_byte;
      else begin
        b = 8'($urandom());
        while (b == marker_cfg.end_byte) b = 8'($urandom());
      end
      send_byte(b);
    end else send_byte(marker_cfg.end_byte);
  endtask

  task automatic send_random_frames(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = rx_sent + n_bytes;
    while (rx_sent < stop_at) send_random_frame();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_register_reset();
    check_marker(REG_START_BYTE, 8'hA5);
    check_marker(REG_END_BYTE,   8'h5A);
    check_marker(REG_WRITE_CMD,  8'h01);
    check_marker(REG_READ_CMD,   8'h02);
  endtask

  // Hand-picked frames under the reset markers
  task automatic test_directed_frames();
    logic [7:0] seq [$];
    seq = '{
      8'h00, 8'hFF,                                        // hunting: dropped
      8'hA5, 8'h02, 8'h04, 8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h5A,  // read frame, markers as data
      8'hA5, 8'h33,                                        // unknown command
      8'hA5, 8'h01, 8'h21,                                 // length one over the limit
      8'hA5, 8'h01, 8'h00, 8'h77,                          // wrong end byte
      // start byte as bad command, bad length and bad end byte, then an empty frame
      8'hA5, 8'hA5, 8'h01, 8'hA5, 8'h02, 8'h01, 8'hFF, 8'hA5, 8'h01, 8'h00, 8'h5A
    };
    foreach (seq[i]) send_byte(seq[i]);
    drain_results();
  endtask

  task automatic test_random_default();
    send_random_frames(50);
    // a stretch with neither side idling
    idle_tx    = 1'b0;
    ready_free = 1'b1;
    send_random_frames(20);
    drain_results();
    idle_tx    = 1'b1;
    ready_free = 1'b0;
  endtask

  // Marker extremes, equal commands and a random setting
  task automatic test_marker_settings();
    set_markers(8'h00, 8'hFF, 8'hFF, 8'h00);
    send_random_frames(25);
    drain_results();
    set_markers(8'hFF, 8'h00, 8'h7F, 8'h7F);
    send_random_frames(25);
    drain_results();
    set_markers(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
    send_random_frames(25);
    drain_results();
    set_markers(8'hA5, 8'h5A, 8'h01, 8'h02);
  endtask

  // Long output hold-off while bytes keep coming, so the input stalls
  task automatic test_backpressure();
    idle_tx  = 1'b0;
    hold_req = 1'b1;
    send_random_frames(40);
    drain_results();
    idle_tx  = 1'b1;
  endtask

  initial begin : main
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    rst_ni        <= 1'b0;
    marker_cfg     = '{start_byte: 8'hA5, end_byte: 8'h5A, write_command: 8'h01,
                       read_command: 8'h02};
    clear_frame_state();
    cnt_drop = '0; cnt_good = '0; cnt_bad = '0;
    cnt_bad_cmd = '0; cnt_bad_len = '0; cnt_bad_eof = '0;
    mismatch_count = 0;
    rx_sent        = 0;
    results_seen   = 0;
    idle_tx        = 1'b1;
    ready_free     = 1'b0;
    hold_req       = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_directed_frames();
    test_random_default();
    test_marker_settings();
    test_backpressure();

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d bytes, checked %0d results: %0d good frames, %0d frame errors, %0d drops",
             rx_sent, results_seen, cnt_good, cnt_bad, cnt_drop);
    $display("Covered reset, extreme, equal-command and random markers plus a long output stall");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
